[rtl/swm_pkg.sv]
package swm_pkg;

   typedef logic signed [31:0] pix_type;

   // control for one cell of the recent-pixel chain
   typedef struct packed {
      logic shift;   // take neighbor pixel
      logic load;    // copy incoming pixel into scan reg
      logic scan;    // scan reg takes upper neighbor's scan value
   } pcell_ctl_type;

   // control for one cell of the row-minimum line chain
   typedef struct packed {
      logic rd;      // registered read at column address
      logic wr;      // write lower neighbor's read data (cell 0: new row minimum) at column address
      logic load;    // copy read data into scan reg
      logic scan;    // scan reg takes upper neighbor's scan value
   } lcell_ctl_type;

endpackage

[rtl/sliding_window_min_2d.sv]
// Two-dimensional sliding-window minimum over a square image streamed in raster
// order, one pixel per request. For each pixel whose row and column are both at
// least window_len-1 it returns the minimum of the window_len x window_len window
// ending there; rsp_tlast marks the last result of a row, rsp_tuser the last of
// the frame. The minimum is separable: a chain of pixel cells holds the most
// recent pixels of the row, and a chain of line cells, each holding one earlier
// row of row minima in its own memory, gives the column. One request is worked
// at a time. A pixel that yields a result passes through the row scan, the line
// write, the column scan and the output load, then returns to idle, where the
// next request is taken; a pixel in the first window_len-1 columns returns to
// idle from the row-scan state without scanning, and any other pixel in the
// first window_len-1 rows returns to idle after the line write. The output load
// waits only while the result register is still full; otherwise the result
// register lets the next request start while a result waits on rsp_tready. A csr
// write restarts the frame at row 0, column 0 unless a request is also accepted.
module sliding_window_min_2d
   import swm_pkg::*;
#(
   parameter int MAX_SIZE   = 1024,
   parameter int MAX_WINDOW = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request: pixel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] pixel
   // result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [31:0] window_min
   output logic        rsp_tlast,     // row_last
   output logic        rsp_tuser,     // [0] frame_last
   // configuration: 0 image_size, 1 window_len
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SIZE > 1 ? MAX_SIZE : 2);
   localparam int KW = $clog2(MAX_WINDOW + 1);
   localparam int NP = MAX_WINDOW;
   localparam int NL = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
   localparam int SI = (MAX_WINDOW > 1) ? 1 : 0;

   localparam logic CSR_SIZE = 1'b0;
   localparam logic CSR_WIN  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE, S_ROW, S_WR, S_COL, S_DONE
   } state_type;

   state_type   state_ff;
   logic [10:0] size_ff;
   logic [5:0]  win_ff;
   logic [AW-1:0] col_ff, row_ff, cur_col_ff, cur_row_ff;
   logic [KW-1:0] k_ff;
   pix_type     rmin_ff, wmin_ff;
   logic        rsp_valid_ff;
   pix_type     rsp_data_ff;
   logic        rsp_last_ff, rsp_user_ff;

   // effective (clamped) sizes
   int unsigned size_i, win_i;
   always_comb begin
      if (size_ff == '0) begin
         size_i = 1;
      end else if (32'(size_ff) > MAX_SIZE) begin
         size_i = MAX_SIZE;
      end else begin
         size_i = 32'(size_ff);
      end
      if (win_ff == '0) begin
         win_i = 1;
      end else if (32'(win_ff) > MAX_WINDOW) begin
         win_i = MAX_WINDOW;
      end else begin
         win_i = 32'(win_ff);
      end
   end

   logic accept;
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // ---- pixel cell chain: cell 0 is the newest pixel
   pcell_ctl_type pctl;
   pix_type pix_o  [NP];
   pix_type pscan_o[NP];

   always_comb begin
      pctl.shift = accept;
      pctl.load  = accept;
      pctl.scan  = (state_ff == S_ROW) && (32'(k_ff) < win_i);
   end

   for (genvar j = 0; j < NP; j++) begin : g_pix
      pix_type pin, sin;
      if (j == 0) begin : g_first
         assign pin = pix_type'(req_tdata);
      end else begin : g_next
         assign pin = pix_o[j-1];
      end
      if (j == NP - 1) begin : g_top
         assign sin = '0;
      end else begin : g_mid
         assign sin = pscan_o[j+1];
      end
      swm_pix_cell u_cell (
         .clock    (clock),
         .ctl      (pctl),
         .pix_in   (pin),
         .scan_in  (sin),
         .pix_out  (pix_o[j]),
         .scan_out (pscan_o[j])
      );
   end

   // ---- line cell chain: cell j holds row minima of row-1-j
   lcell_ctl_type lctl;
   logic [AW-1:0] laddr;
   pix_type lrd_o  [NL];
   pix_type lscan_o[NL];

   always_comb begin
      lctl.rd   = accept;
      lctl.wr   = (state_ff == S_WR);
      lctl.load = (state_ff == S_WR);
      lctl.scan = (state_ff == S_COL) && (32'(k_ff) < win_i);
   end
   assign laddr = (state_ff == S_IDLE) ? col_ff : cur_col_ff;

   for (genvar j = 0; j < NL; j++) begin : g_line
      pix_type win_d, sin;
      if (j == 0) begin : g_first
         assign win_d = rmin_ff;
      end else begin : g_next
         assign win_d = lrd_o[j-1];
      end
      if (j == NL - 1) begin : g_top
         assign sin = '0;
      end else begin : g_mid
         assign sin = lscan_o[j+1];
      end
      swm_line_cell #(.DEPTH(MAX_SIZE)) u_cell (
         .clock    (clock),
         .ctl      (lctl),
         .addr     (laddr),
         .wr_data  (win_d),
         .scan_in  (sin),
         .rd_data  (lrd_o[j]),
         .scan_out (lscan_o[j])
      );
   end

   // ---- sequencer
   logic col_guard, row_guard, row_end, frame_end;
   logic [AW-1:0] col_in, row_in;
   assign col_guard = (32'(cur_col_ff) + 32'd1) < win_i;   // too few columns yet
   assign row_guard = (32'(cur_row_ff) + 32'd1) < win_i;   // too few rows yet
   assign row_end   = (32'(cur_col_ff) == size_i - 32'd1);
   assign frame_end = row_end && (32'(cur_row_ff) == size_i - 32'd1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (32'(col_ff) + 32'd1 >= size_i) begin
         col_in = '0;
         if (32'(row_ff) + 32'd1 >= size_i) begin
            row_in = '0;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= 11'd8;
         win_ff       <= 6'd3;
         col_ff       <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE: size_ff <= csr_wdata;
               CSR_WIN:  win_ff  <= csr_wdata[5:0];
               default:  ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cur_col_ff <= col_ff;
                  cur_row_ff <= row_ff;
                  col_ff     <= col_in;
                  row_ff     <= row_in;
                  rmin_ff    <= pix_type'(req_tdata);
                  k_ff       <= KW'(1);
                  state_ff   <= S_ROW;
               end
            end
            S_ROW: begin
               if (col_guard) begin
                  state_ff <= S_IDLE;
               end else if (32'(k_ff) < win_i) begin
                  if (pscan_o[SI] < rmin_ff) begin
                     rmin_ff <= pscan_o[SI];
                  end
                  k_ff <= k_ff + 1'b1;
               end else begin
                  state_ff <= S_WR;
               end
            end
            S_WR: begin
               wmin_ff <= rmin_ff;
               k_ff    <= KW'(1);
               state_ff <= row_guard ? S_IDLE : S_COL;
            end
            S_COL: begin
               if (32'(k_ff) < win_i) begin
                  if (lscan_o[0] < wmin_ff) begin
                     wmin_ff <= lscan_o[0];
                  end
                  k_ff <= k_ff + 1'b1;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= wmin_ff;
                  rsp_last_ff  <= row_end;
                  rsp_user_ff  <= frame_end;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---- checks
   a_accept_row: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_ROW)
      else $error("accepted request did not start row scan");

   a_col_rows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COL |-> !row_guard)
      else $error("column scan before enough rows");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW || state_ff == S_COL) |-> 32'(k_ff) <= win_i)
      else $error("scan step past window");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < size_i && 32'(row_ff) < size_i)
      else $error("position outside image");

endmodule

[rtl/swm_pix_cell.sv]
module swm_pix_cell
   import swm_pkg::*;
(
   input  logic          clock,
   input  pcell_ctl_type ctl,
   input  pix_type       pix_in,
   input  pix_type       scan_in,
   output pix_type       pix_out,
   output pix_type       scan_out
);

   pix_type pix_ff;
   pix_type scan_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         pix_ff <= pix_in;
      end
      if (ctl.load) begin
         scan_ff <= pix_in;
      end else if (ctl.scan) begin
         scan_ff <= scan_in;
      end
   end

   assign pix_out  = pix_ff;
   assign scan_out = scan_ff;

endmodule

[rtl/swm_line_cell.sv]
module swm_line_cell
   import swm_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  lcell_ctl_type                    ctl,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  pix_type                          wr_data,
   input  pix_type                          scan_in,
   output pix_type                          rd_data,
   output pix_type                          scan_out
);

   // one stored row of row minima, one entry per column
   pix_type mem [DEPTH];
   pix_type rd_ff;
   pix_type scan_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         scan_ff <= rd_ff;
      end else if (ctl.scan) begin
         scan_ff <= scan_in;
      end
   end

   assign rd_data  = rd_ff;
   assign scan_out = scan_ff;

endmodule
